// ===== sv/ray_segment_intersect_core_macros.svh =====
// Assertion macros for the ray/segment intersection core checker.
// Needs a clk and an active-high rst in the scope of use.
`ifndef RAY_SEGMENT_INTERSECT_CORE_MACROS_SVH
`define RAY_SEGMENT_INTERSECT_CORE_MACROS_SVH

// Check a property on every clock outside reset.
`define RSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock.
`define RSI_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== sv/rsi_pkg.sv =====
// Shared constants, types and helper functions for the ray/segment core.
// No dependencies; used by the setup sequencer, the divider and the top level.
package rsi_pkg;

  localparam int FRAC_BITS = 16;   // coordinate fraction bits
  localparam int UNIT_BITS = 28;   // fraction bits of unit vectors

  // register indexes on the write port
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_SEG_START_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SEG_START_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SEG_END_X   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SEG_END_Y   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE   = 3'd4;

  // divider geometry
  localparam int NUM_W = 122;  // numerator bits
  localparam int DEN_W = 61;   // divisor bits
  localparam int QW    = 63;   // quotient bits
  localparam int LANES = 4;

  // divider lanes
  localparam int LANE_T = 0;   // ray parameter
  localparam int LANE_A = 1;   // along-segment correction
  localparam int LANE_X = 2;   // hit offset x
  localparam int LANE_Y = 3;   // hit offset y

  localparam logic [QW-1:0] CAP_BIG = 63'h4000000000000000;
  localparam logic [30:0]   CAP_T   = 31'h7FFFFFFF;

  typedef struct packed {
    logic               ok;
    logic signed [29:0] dx;
    logic signed [29:0] dy;
    logic signed [63:0] len;
    logic signed [15:0] nqx;
    logic signed [15:0] nqy;
  } seg_t;

  typedef struct packed {
    logic               miss;
    logic               den_pos;
    logic               sdd;
    logic               sex;
    logic               sey;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [63:0] wd;
  } side_t;

  typedef logic [LANES-1:0][NUM_W-1:0] lanes_num_t;
  typedef logic [LANES-1:0][QW-1:0]    lanes_q_t;

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    abs64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [QW-1:0] sat_big(input logic [QW-1:0] q, input logic ovf);
    sat_big = (ovf || q > CAP_BIG) ? CAP_BIG : q;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [64:0] v);
    logic signed [64:0] hi_lim;
    logic signed [64:0] lo_lim;
    hi_lim = 65'sd2147483647;
    lo_lim = -65'sd2147483648;
    if (v > hi_lim) clamp32 = 32'sh7FFFFFFF;
    else if (v < lo_lim) clamp32 = 32'sh80000000;
    else clamp32 = v[31:0];
  endfunction

endpackage

// ===== sv/rsi_setup.sv =====
// Segment setup sequencer: unit direction, length and Q1.14 normal.
// Depends on rsi_pkg; runs once after each endpoint write.
module rsi_setup (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  start_x,
  input  logic signed [31:0]  start_y,
  input  logic signed [31:0]  end_x,
  input  logic signed [31:0]  end_y,
  output logic                busy,
  output rsi_pkg::seg_t       seg
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIFF = 4'd1;
  localparam logic [3:0] ST_NORM = 4'd2;
  localparam logic [3:0] ST_SQX  = 4'd3;
  localparam logic [3:0] ST_SQY  = 4'd4;
  localparam logic [3:0] ST_ROOT = 4'd5;
  localparam logic [3:0] ST_QUOT = 4'd6;
  localparam logic [3:0] ST_UNIT = 4'd7;
  localparam logic [3:0] ST_LENX = 4'd8;
  localparam logic [3:0] ST_LENY = 4'd9;

  logic [3:0]         state;
  logic signed [32:0] sx, sy;
  logic [32:0]        ax, ay;
  logic [59:0]        sqx;
  logic [62:0]        v, res, bitv;
  logic [5:0]         cnt;
  logic [30:0]        remx, remy;
  logic [57:0]        numx, numy;
  logic [28:0]        ux, uy;
  logic signed [63:0] px;

  logic signed [32:0] diff_x, diff_y;
  logic [32:0]        mag_x, mag_y, m;
  logic [59:0]        sqy;
  logic [62:0]        root_try;
  logic [30:0]        lenr;
  logic [31:0]        tx, ty;
  logic               gex, gey;
  logic [29:0]        rx, ry;
  logic [15:0]        mx, my;
  logic signed [62:0] lprod;

  assign diff_x   = {end_x[31], end_x} - {start_x[31], start_x};
  assign diff_y   = {end_y[31], end_y} - {start_y[31], start_y};
  assign mag_x    = diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
  assign mag_y    = diff_y[32] ? 33'(-diff_y) : 33'(diff_y);
  assign m        = (ax > ay) ? ax : ay;
  assign sqy      = ay[29:0] * ay[29:0];
  assign root_try = res + bitv;
  assign lenr     = res[30:0];
  assign tx       = {remx, numx[57]};
  assign ty       = {remy, numy[57]};
  assign gex      = tx >= {1'b0, lenr};
  assign gey      = ty >= {1'b0, lenr};
  // round half away from zero into Q1.14
  assign rx       = (30'(ux) + 30'(1 << (rsi_pkg::UNIT_BITS - 15))) >> (rsi_pkg::UNIT_BITS - 14);
  assign ry       = (30'(uy) + 30'(1 << (rsi_pkg::UNIT_BITS - 15))) >> (rsi_pkg::UNIT_BITS - 14);
  assign mx       = rx[15:0];
  assign my       = ry[15:0];
  assign lprod    = (state == ST_LENX) ? (sx * seg.dx) : (sy * seg.dy);
  assign busy     = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      seg.ok <= 1'b0;
    end else if (start) begin
      state  <= ST_DIFF;
      seg.ok <= 1'b0;
    end else begin
      case (state)
        ST_DIFF: begin
          sx    <= diff_x;
          sy    <= diff_y;
          ax    <= mag_x;
          ay    <= mag_y;
          state <= ST_NORM;
        end
        ST_NORM: begin
          // bring the larger magnitude into [2^29, 2^30)
          if (m == '0) begin
            state <= ST_IDLE;
          end else if (m[32:30] != '0) begin
            ax <= ax >> 1;
            ay <= ay >> 1;
          end else if (!m[29]) begin
            ax <= ax << 1;
            ay <= ay << 1;
          end else begin
            state <= ST_SQX;
          end
        end
        ST_SQX: begin
          sqx   <= ax[29:0] * ax[29:0];
          state <= ST_SQY;
        end
        ST_SQY: begin
          v     <= 63'(sqx) + 63'(sqy);
          res   <= '0;
          bitv  <= 63'(1) << 62;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (v >= root_try) begin
            v   <= v - root_try;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            remx  <= '0;
            remy  <= '0;
            numx  <= {ax[29:0], 28'd0};
            numy  <= {ay[29:0], 28'd0};
            ux    <= '0;
            uy    <= '0;
            cnt   <= 6'd57;
            state <= ST_QUOT;
          end
        end
        ST_QUOT: begin
          remx <= gex ? 31'(tx - {1'b0, lenr}) : tx[30:0];
          remy <= gey ? 31'(ty - {1'b0, lenr}) : ty[30:0];
          numx <= numx << 1;
          numy <= numy << 1;
          ux   <= {ux[27:0], gex};
          uy   <= {uy[27:0], gey};
          cnt  <= cnt - 6'd1;
          if (cnt == '0) state <= ST_UNIT;
        end
        ST_UNIT: begin
          seg.dx  <= sx[32] ? -$signed({1'b0, ux}) : $signed({1'b0, ux});
          seg.dy  <= sy[32] ? -$signed({1'b0, uy}) : $signed({1'b0, uy});
          seg.nqy <= sx[32] ? -$signed(mx) : $signed(mx);
          seg.nqx <= sy[32] ? $signed(my) : -$signed(my);
          state   <= ST_LENX;
        end
        ST_LENX: begin
          px    <= 64'(lprod);
          state <= ST_LENY;
        end
        ST_LENY: begin
          seg.len <= px + 64'(lprod);
          seg.ok  <= 1'b1;
          state   <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/rsi_div.sv =====
// Four-lane pipelined restoring divider with one shared divisor, one quotient bit a stage.
// Depends on rsi_pkg; carries the side payload alongside the quotients.
module rsi_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [rsi_pkg::DEN_W-1:0] divisor,
  input  rsi_pkg::lanes_num_t num,
  input  rsi_pkg::side_t      side_in,
  output logic                out_valid,
  output rsi_pkg::lanes_q_t   quo,
  output logic [rsi_pkg::LANES-1:0] ovf,
  output rsi_pkg::side_t      side_out
);

  localparam int QW    = rsi_pkg::QW;
  localparam int DEN_W = rsi_pkg::DEN_W;
  localparam int NUM_W = rsi_pkg::NUM_W;
  localparam int LANES = rsi_pkg::LANES;

  logic [DEN_W-1:0]   rem_s  [0:QW][LANES];
  logic [QW-1:0]      low_s  [0:QW][LANES];
  logic [QW-1:0]      q_s    [0:QW][LANES];
  logic               ovf_s  [0:QW][LANES];
  logic [DEN_W-1:0]   d_s    [0:QW];
  rsi_pkg::side_t     side_s [0:QW];
  logic               v_s    [0:QW];

  // entry: flag quotients that do not fit in QW bits
  always_ff @(posedge clk) begin
    logic [DEN_W-1:0] hi_w;
    logic             o;
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        hi_w = DEN_W'(num[l][NUM_W-1:QW]);
        o    = hi_w >= divisor;
        ovf_s[0][l] <= o;
        rem_s[0][l] <= o ? '0 : hi_w;
        low_s[0][l] <= num[l][QW-1:0];
        q_s[0][l]   <= '0;
      end
      d_s[0]    <= divisor;
      side_s[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v_s[0] <= 1'b0;
    else if (en) v_s[0] <= in_valid;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] t;
      logic [DEN_W:0] diff;
      logic           ge;
      assign t    = {rem_s[k-1][l], low_s[k-1][l][QW-1]};
      assign diff = t - {1'b0, d_s[k-1]};
      assign ge   = t >= {1'b0, d_s[k-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[k][l] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
          low_s[k][l] <= {low_s[k-1][l][QW-2:0], 1'b0};
          q_s[k][l]   <= {q_s[k-1][l][QW-2:0], ge};
          ovf_s[k][l] <= ovf_s[k-1][l];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_s[k]    <= d_s[k-1];
        side_s[k] <= side_s[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) v_s[k] <= 1'b0;
      else if (en) v_s[k] <= v_s[k-1];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo[l] = q_s[QW][l];
    assign ovf[l] = ovf_s[QW][l];
  end
  assign out_valid = v_s[QW];
  assign side_out  = side_s[QW];

endmodule

// ===== sv/ray_segment_intersect_core.sv =====
// Path: stages A to F, the quotient pipeline and stage G, then the output register.
// Throughput: one ray per cycle unless stalled; quotient pipeline of one bit a stage.
// Reset: synchronous; endpoints clear to 0, tolerance to 7, pipeline empties.
// An endpoint write starts the segment setup sequencer (normalize shifts, 32 root steps,
// 58 quotient steps); in_stall holds until it ends.
// A stall on a held result freezes the whole pipeline; it loses and repeats nothing.
module ray_segment_intersect_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [rsi_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [31:0]         wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  origin_x,
  input  logic signed [31:0]  origin_y,
  input  logic signed [31:0]  dir_x,
  input  logic signed [31:0]  dir_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                hit,
  output logic [30:0]         distance,
  output logic signed [31:0]  hit_x,
  output logic signed [31:0]  hit_y,
  output logic signed [15:0]  normal_x,
  output logic signed [15:0]  normal_y
);

  localparam int NUM_W = rsi_pkg::NUM_W;
  localparam int DEN_W = rsi_pkg::DEN_W;
  localparam int UB    = rsi_pkg::UNIT_BITS;

  // ---------------------------------------------------------------- config
  logic signed [31:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
  logic [15:0]        tolerance;
  logic               seg_write;
  logic               setup_busy;
  rsi_pkg::seg_t      seg;

  assign seg_write = wr_en && (wr_index inside {[rsi_pkg::REG_SEG_START_X :
                                                 rsi_pkg::REG_SEG_END_Y]});

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_start_x <= '0;
      seg_start_y <= '0;
      seg_end_x   <= '0;
      seg_end_y   <= '0;
      tolerance   <= 16'd7;
    end else if (wr_en) begin
      case (wr_index)
        rsi_pkg::REG_SEG_START_X: seg_start_x <= wr_data;
        rsi_pkg::REG_SEG_START_Y: seg_start_y <= wr_data;
        rsi_pkg::REG_SEG_END_X:   seg_end_x   <= wr_data;
        rsi_pkg::REG_SEG_END_Y:   seg_end_y   <= wr_data;
        rsi_pkg::REG_TOLERANCE:   tolerance   <= wr_data[15:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // derive unit direction, normal and length whenever an endpoint is written
  rsi_setup u_setup (
    .clk     (clk),
    .rst     (rst),
    .start   (seg_write),
    .start_x (seg_start_x),
    .start_y (seg_start_y),
    .end_x   (seg_end_x),
    .end_y   (seg_end_y),
    .busy    (setup_busy),
    .seg     (seg)
  );

  // ---------------------------------------------------------------- flow
  // advance every stage together unless a finished result is held
  logic en;
  logic in_xfer;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en || setup_busy || seg_write;
  assign in_xfer  = in_valid && !in_stall;

  logic a_v, b_v, c_v, d_v, e_v, f_v, g_v, div_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      d_v       <= 1'b0;
      e_v       <= 1'b0;
      f_v       <= 1'b0;
      g_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_v       <= in_xfer;
      b_v       <= a_v;
      c_v       <= b_v;
      d_v       <= c_v;
      e_v       <= d_v;
      f_v       <= e_v;
      g_v       <= div_v;
      out_valid <= g_v;
    end
  end

  // ---------------------------------------------------------------- stage A
  // register the ray and the origin offset from the first endpoint
  logic signed [31:0] a_ox, a_oy, a_ex, a_ey;
  logic signed [32:0] a_wx, a_wy;

  always_ff @(posedge clk) begin
    if (en) begin
      a_ox <= origin_x;
      a_oy <= origin_y;
      a_ex <= dir_x;
      a_ey <= dir_y;
      a_wx <= {origin_x[31], origin_x} - {seg_start_x[31], seg_start_x};
      a_wy <= {origin_y[31], origin_y} - {seg_start_y[31], seg_start_y};
    end
  end

  // ---------------------------------------------------------------- stage B
  // eight products against the segment normal n = (-dy, dx) and direction d
  logic signed [29:0] nx, ny;
  logic signed [62:0] b_exn, b_eyn, b_wxn, b_wyn, b_exd, b_eyd, b_wxd, b_wyd;
  logic signed [31:0] b_ox, b_oy, b_ex, b_ey;

  assign nx = -seg.dy;
  assign ny = seg.dx;

  always_ff @(posedge clk) begin
    if (en) begin
      b_exn <= a_ex * nx;
      b_eyn <= a_ey * ny;
      b_wxn <= a_wx * nx;
      b_wyn <= a_wy * ny;
      b_exd <= a_ex * seg.dx;
      b_eyd <= a_ey * seg.dy;
      b_wxd <= a_wx * seg.dx;
      b_wyd <= a_wy * seg.dy;
      b_ox  <= a_ox;
      b_oy  <= a_oy;
      b_ex  <= a_ex;
      b_ey  <= a_ey;
    end
  end

  // ---------------------------------------------------------------- stage C
  logic signed [63:0] c_den, c_num, c_dd, c_wd;
  logic signed [31:0] c_ox, c_oy, c_ex, c_ey;

  always_ff @(posedge clk) begin
    if (en) begin
      c_den <= 64'(b_exn) + 64'(b_eyn);
      c_num <= -(64'(b_wxn) + 64'(b_wyn));
      c_dd  <= 64'(b_exd) + 64'(b_eyd);
      c_wd  <= 64'(b_wxd) + 64'(b_wyd);
      c_ox  <= b_ox;
      c_oy  <= b_oy;
      c_ex  <= b_ex;
      c_ey  <= b_ey;
    end
  end

  // ---------------------------------------------------------------- stage D
  // early miss tests: degenerate segment, parallel ray, crossing behind origin
  logic [63:0] den_abs, num_abs, dd_abs, eps28;
  logic        miss_c;

  assign den_abs = rsi_pkg::abs64(c_den);
  assign num_abs = rsi_pkg::abs64(c_num);
  assign dd_abs  = rsi_pkg::abs64(c_dd);
  assign eps28   = 64'(tolerance) << UB;
  assign miss_c  = !seg.ok || (c_den == '0) || (den_abs < eps28) || (c_num == '0) ||
                   (c_num[63] != c_den[63]);

  logic               d_miss, d_den_pos, d_sdd, d_sex, d_sey;
  logic [DEN_W-1:0]   d_den_m;
  logic [60:0]        d_num_m;
  logic [59:0]        d_dd_m;
  logic [31:0]        d_ex_m, d_ey_m;
  logic signed [31:0] d_ox, d_oy;
  logic signed [63:0] d_wd;

  always_ff @(posedge clk) begin
    if (en) begin
      d_miss    <= miss_c;
      d_den_pos <= !c_den[63];
      d_sdd     <= c_dd[63];
      d_sex     <= c_ex[31];
      d_sey     <= c_ey[31];
      d_den_m   <= den_abs[DEN_W-1:0];
      d_num_m   <= num_abs[60:0];
      d_dd_m    <= dd_abs[59:0];
      d_ex_m    <= rsi_pkg::abs32(c_ex);
      d_ey_m    <= rsi_pkg::abs32(c_ey);
      d_ox      <= c_ox;
      d_oy      <= c_oy;
      d_wd      <= c_wd;
    end
  end

  // ---------------------------------------------------------------- stage E
  // split the wide numerator products into partial products of 32-bit slices
  logic [63:0]      e_p00, e_p01, e_p10, e_p11, e_x0, e_x1, e_y0, e_y1;
  logic [60:0]      e_num_m;
  logic [DEN_W-1:0] e_den_m;
  rsi_pkg::side_t   e_side;

  always_ff @(posedge clk) begin
    if (en) begin
      e_p00          <= 64'(d_num_m[31:0])  * 64'(d_dd_m[31:0]);
      e_p01          <= 64'(d_num_m[31:0])  * 64'(d_dd_m[59:32]);
      e_p10          <= 64'(d_num_m[60:32]) * 64'(d_dd_m[31:0]);
      e_p11          <= 64'(d_num_m[60:32]) * 64'(d_dd_m[59:32]);
      e_x0           <= 64'(d_ex_m) * 64'(d_num_m[31:0]);
      e_x1           <= 64'(d_ex_m) * 64'(d_num_m[60:32]);
      e_y0           <= 64'(d_ey_m) * 64'(d_num_m[31:0]);
      e_y1           <= 64'(d_ey_m) * 64'(d_num_m[60:32]);
      e_num_m        <= d_num_m;
      e_den_m        <= d_den_m;
      e_side.miss    <= d_miss;
      e_side.den_pos <= d_den_pos;
      e_side.sdd     <= d_sdd;
      e_side.sex     <= d_sex;
      e_side.sey     <= d_sey;
      e_side.ox      <= d_ox;
      e_side.oy      <= d_oy;
      e_side.wd      <= d_wd;
    end
  end

  // ---------------------------------------------------------------- stage F
  rsi_pkg::lanes_num_t f_num;
  logic [DEN_W-1:0]    f_den;
  rsi_pkg::side_t      f_side;

  always_ff @(posedge clk) begin
    if (en) begin
      f_num[rsi_pkg::LANE_T] <= NUM_W'(e_num_m) << rsi_pkg::FRAC_BITS;
      f_num[rsi_pkg::LANE_A] <= NUM_W'(e_p00) + (NUM_W'(e_p01) << 32) +
                                (NUM_W'(e_p10) << 32) + (NUM_W'(e_p11) << 64);
      f_num[rsi_pkg::LANE_X] <= NUM_W'(e_x0) + (NUM_W'(e_x1) << 32);
      f_num[rsi_pkg::LANE_Y] <= NUM_W'(e_y0) + (NUM_W'(e_y1) << 32);
      f_den                  <= e_den_m;
      f_side                 <= e_side;
    end
  end

  // ---------------------------------------------------------------- divider
  rsi_pkg::lanes_q_t            div_q;
  logic [rsi_pkg::LANES-1:0]    div_ovf;
  rsi_pkg::side_t               div_side;

  rsi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_v),
    .divisor   (f_den),
    .num       (f_num),
    .side_in   (f_side),
    .out_valid (div_v),
    .quo       (div_q),
    .ovf       (div_ovf),
    .side_out  (div_side)
  );

  // ---------------------------------------------------------------- stage G
  // saturate quotients, apply signs, add back the along and origin terms
  logic [30:0]        qt;
  logic signed [64:0] qa_s, qx_s, qy_s;

  assign qt   = (div_ovf[rsi_pkg::LANE_T] || (div_q[rsi_pkg::LANE_T][62:31] != '0)) ?
                rsi_pkg::CAP_T : div_q[rsi_pkg::LANE_T][30:0];
  assign qa_s = $signed({2'b00, rsi_pkg::sat_big(div_q[rsi_pkg::LANE_A],
                                                 div_ovf[rsi_pkg::LANE_A])});
  assign qx_s = $signed({2'b00, rsi_pkg::sat_big(div_q[rsi_pkg::LANE_X],
                                                 div_ovf[rsi_pkg::LANE_X])});
  assign qy_s = $signed({2'b00, rsi_pkg::sat_big(div_q[rsi_pkg::LANE_Y],
                                                 div_ovf[rsi_pkg::LANE_Y])});

  logic [30:0]        g_tq;
  logic signed [64:0] g_along, g_hx, g_hy;
  logic               g_miss, g_den_pos;

  always_ff @(posedge clk) begin
    if (en) begin
      g_tq      <= qt;
      g_along   <= 65'(div_side.wd) + (div_side.sdd ? -qa_s : qa_s);
      g_hx      <= 65'(div_side.ox) + (div_side.sex ? -qx_s : qx_s);
      g_hy      <= 65'(div_side.oy) + (div_side.sey ? -qy_s : qy_s);
      g_miss    <= div_side.miss;
      g_den_pos <= div_side.den_pos;
    end
  end

  // ---------------------------------------------------------------- stage H
  // near-origin and extent tests, then the output register
  logic signed [65:0] eps28_s, along_w, len_hi;
  logic               miss_g;

  assign eps28_s = $signed(66'(tolerance) << UB);
  assign along_w = 66'(g_along);
  assign len_hi  = 66'(seg.len) + eps28_s;
  assign miss_g  = g_miss || (g_tq <= 31'(tolerance)) || (along_w < -eps28_s) ||
                   (along_w > len_hi);

  always_ff @(posedge clk) begin
    if (en) begin
      hit      <= !miss_g;
      distance <= miss_g ? '0 : g_tq;
      hit_x    <= miss_g ? '0 : rsi_pkg::clamp32(g_hx);
      hit_y    <= miss_g ? '0 : rsi_pkg::clamp32(g_hy);
      // flip the normal to face the incoming ray
      normal_x <= miss_g ? '0 : (g_den_pos ? -seg.nqx : seg.nqx);
      normal_y <= miss_g ? '0 : (g_den_pos ? -seg.nqy : seg.nqy);
    end
  end

endmodule

// ===== sv/rsi_chk.sv =====
// Port-level checker for the ray/segment intersection core, bound to the top level.
// Depends on rsi_pkg and the assertion macro header.
`include "ray_segment_intersect_core_macros.svh"

module rsi_chk (
  input logic                clk,
  input logic                rst,
  input logic                wr_en,
  input logic [rsi_pkg::REG_IDX_W-1:0] wr_index,
  input logic [31:0]         wr_data,
  input logic                in_valid,
  input logic                in_stall,
  input logic signed [31:0]  origin_x,
  input logic signed [31:0]  origin_y,
  input logic signed [31:0]  dir_x,
  input logic signed [31:0]  dir_y,
  input logic                out_valid,
  input logic                out_stall,
  input logic                hit,
  input logic [30:0]         distance,
  input logic signed [31:0]  hit_x,
  input logic signed [31:0]  hit_y,
  input logic signed [15:0]  normal_x,
  input logic signed [15:0]  normal_y
);

  // a held result stays offered
  `RSI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // a miss carries all-zero fields
  `RSI_ASSERT(a_miss_zero, !(out_valid && !hit) || (distance == '0 && hit_x == '0 && hit_y == '0 && normal_x == '0 && normal_y == '0), "miss with nonzero fields")

  // a hit lies strictly ahead of the origin
  `RSI_ASSERT(a_hit_ahead, !(out_valid && hit) || (distance != '0), "hit at zero distance")

  // an endpoint write blocks input while the segment is rebuilt
  `RSI_ASSERT_NEXT(a_setup_stall, wr_en && (wr_index == rsi_pkg::REG_SEG_START_X || wr_index == rsi_pkg::REG_SEG_START_Y || wr_index == rsi_pkg::REG_SEG_END_X || wr_index == rsi_pkg::REG_SEG_END_Y), in_stall, "input open during segment setup")

endmodule

bind ray_segment_intersect_core rsi_chk u_rsi_chk (.*);

// ===== verif/tb_ray_segment_intersect_core.sv =====
// Testbench for ray_segment_intersect_core: directed and random rays against several segments.
// Depends on rsi_pkg for register indexes; predicts each result in-line and checks in order.
`timescale 1ns / 1ps

module tb_ray_segment_intersect_core;
  import rsi_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS;   // 1.0 in coordinate format
  localparam int LATENCY_WAIT = 90;                      // pipeline depth plus margin
  localparam int LONG_HOLD = 400;                        // receiver hold-off, in cycles

  typedef struct packed {
    logic               hit;
    logic [30:0]        distance;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
  } ray_result_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [31:0]          wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [31:0]   origin_x, origin_y, dir_x, dir_y;
  logic                 out_valid;
  logic                 out_stall;
  logic                 hit;
  logic [30:0]          distance;
  logic signed [31:0]   hit_x, hit_y;
  logic signed [15:0]   normal_x, normal_y;

  // Shadow copy of the configuration registers.
  logic signed [31:0] seg_p0x, seg_p0y, seg_p1x, seg_p1y;
  logic [15:0]        seg_tol;

  ray_result_t pending_hits[$];
  int  err_count;
  bit  tx_idle_en;     // sender inserts random gaps
  bit  rx_idle_en;     // receiver inserts random stall bursts
  int  hold_ask, hold_served, hold_cnt, stall_left;

  ray_segment_intersect_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction
  function automatic longint unsigned mag(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned quot_sat(input logic [127:0] n, input longint unsigned d,
                                               input longint unsigned cap);
    logic [127:0] q;
    q = n / {64'd0, d};
    return (q > {64'd0, cap}) ? cap : q[63:0];
  endfunction

  // a*b/d truncated toward zero, magnitude capped
  function automatic longint scaled_quot(input longint a, input longint b, input longint d,
                                         input longint unsigned cap);
    logic [127:0]    prod;
    longint unsigned q;
    if (d == 0) return 0;
    prod = {64'd0, mag(a)} * {64'd0, mag(b)};
    q = quot_sat(prod, mag(d), cap);
    return ((a < 0) ^ ((b < 0) ^ (d < 0))) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits >>= 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v -= res + bits;
        res = (res >> 1) + bits;
      end else res >>= 1;
      bits >>= 2;
    end
    return res;
  endfunction

  // Unit direction of the segment in Q2.28; returns 0 for a zero-length segment.
  function automatic bit seg_direction(input longint sx, input longint sy,
                                       output longint ux, output longint uy);
    longint unsigned ax, ay, m, len;
    ax = mag(sx);
    ay = mag(sy);
    m = ax > ay ? ax : ay;
    ux = 0;
    uy = 0;
    if (m == 0) return 0;
    while (m >= (64'd1 << 30)) begin ax >>= 1; ay >>= 1; m >>= 1; end
    while (m < (64'd1 << 29)) begin ax <<= 1; ay <<= 1; m <<= 1; end
    len = root_floor(ax * ax + ay * ay);
    ux = (ax << UNIT_BITS) / len;
    uy = (ay << UNIT_BITS) / len;
    if (sx < 0) ux = -ux;
    if (sy < 0) uy = -uy;
    return 1;
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [15:0] unit_to_q14(input longint v);
    longint unsigned m;
    m = (mag(v) + (64'd1 << (UNIT_BITS - 15))) >> (UNIT_BITS - 14);
    return v < 0 ? 16'(-m) : 16'(m);
  endfunction

  function automatic ray_result_t predict_hit(input logic signed [31:0] ox_i, oy_i, ex_i, ey_i);
    ray_result_t r;
    longint ox, oy, ex, ey, sx, sy, eps, eps28;
    longint ux, uy, nx, ny, den, wx, wy, num, tq, along, len, hx, hy;
    r = '0;
    ox = ox_i; oy = oy_i; ex = ex_i; ey = ey_i;
    sx = longint'(seg_p1x) - longint'(seg_p0x);
    sy = longint'(seg_p1y) - longint'(seg_p0y);
    eps = longint'(seg_tol);
    eps28 = eps << UNIT_BITS;
    if (!seg_direction(sx, sy, ux, uy)) return r;
    nx = -uy;
    ny = ux;
    den = ex * nx + ey * ny;
    if (den == 0 || mag(den) < longint'(eps28)) return r;
    wx = ox - longint'(seg_p0x);
    wy = oy - longint'(seg_p0y);
    num = -(wx * nx + wy * ny);
    if (num == 0 || ((num < 0) != (den < 0))) return r;
    tq = scaled_quot(num, ONE, den, 64'h7FFFFFFF);
    if (tq <= eps) return r;
    along = wx * ux + wy * uy + scaled_quot(num, ex * ux + ey * uy, den, 64'd1 << 62);
    len = sx * ux + sy * uy;
    if (along < -eps28 || along > len + eps28) return r;
    hx = sat32(ox + scaled_quot(ex, num, den, 64'd1 << 62));
    hy = sat32(oy + scaled_quot(ey, num, den, 64'd1 << 62));
    if (den > 0) begin nx = -nx; ny = -ny; end
    r.hit = 1'b1;
    r.distance = tq[30:0];
    r.hit_x = hx[31:0];
    r.hit_y = hy[31:0];
    r.normal_x = unit_to_q14(nx);
    r.normal_y = unit_to_q14(ny);
    return r;
  endfunction

  // ---------------------------------------------------------------- receiver side
  // Random stall bursts, plus a long hold-off whenever a test asks for one.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
      stall_left <= 0;
    end else if (hold_ask != hold_served) begin
      hold_served <= hold_ask;
      hold_cnt <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // Compare every transfer on the result side against the oldest prediction.
  always @(posedge clk) begin
    ray_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0d distance=%h", $time, hit, distance);
        err_count++;
      end else begin
        want = pending_hits.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, hit);
          err_count++;
        end
        if (distance !== want.distance) begin
          $display("%0t: distance expected %h actual %h", $time, want.distance, distance);
          err_count++;
        end
        if (hit_x !== want.hit_x) begin
          $display("%0t: hit_x expected %h actual %h", $time, want.hit_x, hit_x);
          err_count++;
        end
        if (hit_y !== want.hit_y) begin
          $display("%0t: hit_y expected %h actual %h", $time, want.hit_y, hit_y);
          err_count++;
        end
        if (normal_x !== want.normal_x) begin
          $display("%0t: normal_x expected %h actual %h", $time, want.normal_x, normal_x);
          err_count++;
        end
        if (normal_y !== want.normal_y) begin
          $display("%0t: normal_y expected %h actual %h", $time, want.normal_y, normal_y);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender side
  // Offer one ray and hold it until the transfer; valid stays high unless an idle gap ends it.
  task automatic send_ray(input logic signed [31:0] ox, oy, ex, ey);
    in_valid <= 1'b1;
    origin_x <= ox;
    origin_y <= oy;
    dir_x <= ex;
    dir_y <= ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_hits.push_back(predict_hit(ox, oy, ex, ey));
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop valid, let every result drain, then give the pipeline time to empty.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    case (idx)
      REG_SEG_START_X: seg_p0x = value;
      REG_SEG_START_Y: seg_p0y = value;
      REG_SEG_END_X:   seg_p1x = value;
      REG_SEG_END_Y:   seg_p1y = value;
      REG_TOLERANCE:   seg_tol = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_segment(input logic signed [31:0] ax, ay, bx, by, input logic [15:0] tol);
    write_reg(REG_SEG_START_X, ax);
    write_reg(REG_SEG_START_Y, ay);
    write_reg(REG_SEG_END_X, bx);
    write_reg(REG_SEG_END_Y, by);
    write_reg(REG_TOLERANCE, {$urandom_range(0, 65535), tol} >> 0 & 32'h0 | {16'($urandom), tol});
    wr_en <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord(input int span_bits);
    return 32'(longint'($urandom_range(0, (1 << span_bits) - 1)) - (longint'(1) << (span_bits - 1)));
  endfunction

  // Aim a ray at a random point on or near the segment; mostly a hit.
  task automatic send_aimed_ray;
    longint tx, ty, ox, oy, ex, ey;
    int frac;
    frac = $urandom_range(0, 1100) - 50;
    tx = longint'(seg_p0x) + (longint'(seg_p1x) - longint'(seg_p0x)) * frac / 1000;
    ty = longint'(seg_p0y) + (longint'(seg_p1y) - longint'(seg_p0y)) * frac / 1000;
    ox = tx + rand_coord($urandom_range(4, 26));
    oy = ty + rand_coord($urandom_range(4, 26));
    ex = (tx - ox) >>> $urandom_range(0, 6);
    ey = (ty - oy) >>> $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0) begin ex = -ex; ey = -ey; end   // aim away
    send_ray(32'(sat32(ox)), 32'(sat32(oy)), 32'(sat32(ex)), 32'(sat32(ey)));
  endtask

  task automatic send_any_ray;
    if ($urandom_range(0, 4) == 0) send_ray($urandom, $urandom, $urandom, $urandom);
    else send_aimed_ray();
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_state;
    // Zero-length segment out of reset: every ray misses.
    send_ray(32'sd0, -32'sd65536, 32'sd0, 32'sd65536);
    send_ray(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
    drain();
  endtask

  task automatic test_directed_rays;
    logic [REG_IDX_W-1:0] idx;
    set_segment(32'sd0, 32'sd0, 32'(10 * ONE), 32'sd0, 16'd7);
    // Write the unused register indexes: they must be ignored.
    for (int i = REG_TOLERANCE + 1; i < (1 << REG_IDX_W); i++) begin
      idx = i;
      write_reg(idx, $urandom);
    end
    wr_en <= 1'b0;
    send_ray(32'(5 * ONE), -32'(5 * ONE), 32'sd0, 32'(ONE));          // plain hit from below
    send_ray(32'(5 * ONE), 32'(5 * ONE), 32'sd0, -32'(ONE));          // plain hit from above
    send_ray(32'(5 * ONE), -32'(5 * ONE), 32'sd0, -32'(ONE));         // crossing behind origin
    send_ray(32'(5 * ONE), -32'(5 * ONE), 32'(ONE), 32'sd0);          // parallel
    send_ray(32'(5 * ONE), -32'(5 * ONE), 32'(ONE), 32'sd3);          // parallel within tolerance
    send_ray(32'(5 * ONE), 32'sd0, 32'sd0, 32'(ONE));                 // origin on segment
    send_ray(32'(5 * ONE), -32'sd7, 32'sd0, 32'(ONE));                // t right at tolerance
    send_ray(32'(5 * ONE), -32'sd8, 32'sd0, 32'(ONE));                // t just past tolerance
    send_ray(32'(10 * ONE) + 32'sd7, -32'(ONE), 32'sd0, 32'(ONE));    // edge within tolerance
    send_ray(32'(10 * ONE) + 32'sd8, -32'(ONE), 32'sd0, 32'(ONE));    // just outside extent
    send_ray(-32'sd8, -32'(ONE), 32'sd0, 32'(ONE));                   // before the start
    send_ray(32'(5 * ONE), -32'(30000 * ONE), 32'sd0, 32'sd1);        // far hit saturates
    send_ray(32'(5 * ONE), -32'(ONE), 32'sd0, 32'sd0);                // zero direction
    send_ray(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
    send_ray(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_ray(32'sd0, 32'sh80000000, 32'sd1, 32'sh7FFFFFFF);
    send_ray(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sd1);
    drain();
  endtask

  task automatic test_tolerance_extremes;
    set_segment(-32'(3 * ONE), -32'(2 * ONE), 32'(4 * ONE), 32'(6 * ONE), 16'd0);
    send_ray(32'sd0, 32'(ONE), 32'sd7, -32'sd6);
    send_ray(-32'(3 * ONE), -32'(2 * ONE), 32'(ONE), -32'(ONE));
    repeat (8) send_aimed_ray();
    drain();
    set_segment(32'(6 * ONE), -32'(ONE), -32'(2 * ONE), 32'(9 * ONE), 16'hFFFF);
    send_ray(32'sd0, 32'sd0, 32'(ONE), 32'(ONE));
    repeat (8) send_aimed_ray();
    drain();
  endtask

  task automatic test_extreme_segments;
    set_segment(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'd7);
    send_ray(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
    repeat (20) send_any_ray();
    drain();
    set_segment(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 16'd1);
    repeat (20) send_any_ray();
    drain();
    // Zero length away from the origin.
    set_segment(32'(ONE), 32'(ONE), 32'(ONE), 32'(ONE), 16'd7);
    send_ray(32'sd0, 32'sd0, 32'(ONE), 32'(ONE));
    repeat (5) send_any_ray();
    drain();
  endtask

  task automatic test_random_rays(input int n_rays);
    for (int s = 0; s < 8; s++) begin
      set_segment(rand_coord($urandom_range(8, 28)), rand_coord($urandom_range(8, 28)),
                  rand_coord($urandom_range(8, 28)), rand_coord($urandom_range(8, 28)),
                  16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64)));
      repeat (n_rays / 8) send_any_ray();
      drain();
    end
  endtask

  task automatic test_backpressure;
    // Hold the result side for a long stretch while rays keep coming.
    set_segment(32'sd0, -32'(4 * ONE), 32'sd0, 32'(4 * ONE), 16'd3);
    tx_idle_en = 1'b0;
    hold_ask++;
    repeat (200) send_aimed_ray();
    tx_idle_en = 1'b1;
    drain();
  endtask

  task automatic test_tail_no_idle;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_segment(32'(2 * ONE), 32'(2 * ONE), -32'(7 * ONE), 32'(5 * ONE), 16'd20);
    repeat (150) send_any_ray();
    drain();
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    in_valid = 1'b0;
    origin_x = '0;
    origin_y = '0;
    dir_x = '0;
    dir_y = '0;
    seg_p0x = '0;
    seg_p0y = '0;
    seg_p1x = '0;
    seg_p1y = '0;
    seg_tol = 16'd7;
    err_count = 0;
    hold_ask = 0;
    hold_served = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_rays();
    test_tolerance_extremes();
    test_extreme_segments();
    test_backpressure();
    test_random_rays(1200);
    test_tail_no_idle();

    if (err_count == 0 && pending_hits.size() == 0) begin
      $display("tb_ray_segment_intersect_core: PASS");
    end else begin
      $display("tb_ray_segment_intersect_core: FAIL");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #20000000;
    $display("tb_ray_segment_intersect_core: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/rsi_pkg.sv
sv/rsi_setup.sv
sv/rsi_div.sv
sv/ray_segment_intersect_core.sv
sv/rsi_chk.sv
verif/tb_ray_segment_intersect_core.sv
